// ===== hw/rtl/kcr_pkg.sv =====
// package for the key combo remap table: types, codes and combo helpers
`timescale 1ns / 1ps
package kcr_pkg;

  localparam int unsigned EntriesPerBankDefault = 16;
  localparam int unsigned ModBytes = 4;
  localparam int unsigned KeyBytes = 6;
  localparam int unsigned ModW = 32;
  localparam int unsigned KeyW = 48;
  localparam int unsigned CntW = 3;
  localparam int unsigned ModPartW = ModW + CntW;
  localparam int unsigned KeyPartW = KeyW + CntW;
  localparam int unsigned EntryW = 2 * ModPartW + 2 * KeyPartW;
  localparam int unsigned RankW = 7;
  localparam int unsigned UsedCountW = 7;
  localparam int unsigned InDataW = 192;
  localparam int unsigned OutDataW = 184;

  typedef enum logic [2:0] {
    REQ_CLEAR    = 3'd0,
    REQ_ADD      = 3'd1,
    REQ_REMOVE   = 3'd2,
    REQ_COUNT    = 3'd3,
    REQ_READ     = 3'd4,
    REQ_CONFLICT = 3'd5,
    REQ_KEY_USED = 3'd6,
    REQ_NONE     = 3'd7
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_READ,
    ST_READ_WAIT,
    ST_DONE
  } state_e;

  typedef logic [ModPartW-1:0] mod_part_t;
  typedef logic [KeyPartW-1:0] key_part_t;

  typedef struct packed {
    mod_part_t tm;
    key_part_t tk;
    mod_part_t om;
    key_part_t ok;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture request
    logic scan_start; // reset scan state
    logic scan_step;  // inspect current slot, advance
    logic wr_entry;   // write captured entry at found slot
    logic wr_zero;    // clear the used mark of the slot being removed
    logic rd_issue;   // issue ram read at found slot
    logic res_set;    // publish result
  } kcr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic   scan_last;
    logic   found;
    logic   free_found;
    req_e   req;
  } kcr_sts_t;

  function automatic logic [2:0] clamp_cnt(input logic [2:0] c, input logic [2:0] mx);
    return (c > mx) ? mx : c;
  endfunction

  // multiset compare of n bytes: count of each byte value equal in both
  function automatic logic mset_eq6(input logic [47:0] a, input logic [47:0] b,
                                    input logic [2:0] n);
    logic ok;
    logic [2:0] ca;
    logic [2:0] cb;
    ok = 1'b1;
    for (int i = 0; i < 6; i++) begin
      ca = '0;
      cb = '0;
      for (int j = 0; j < 6; j++) begin
        if (j < n && a[8*j +: 8] == a[8*i +: 8]) ca = ca + 3'd1;
        if (j < n && b[8*j +: 8] == a[8*i +: 8]) cb = cb + 3'd1;
      end
      if (i < n && ca != cb) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic byte_in(input logic [47:0] w, input logic [2:0] n,
                                   input logic [7:0] k);
    logic f;
    f = 1'b0;
    for (int i = 0; i < 6; i++) begin
      if (i < n && w[8*i +: 8] == k) f = 1'b1;
    end
    return f;
  endfunction

endpackage

// ===== hw/rtl/kcr_ram.sv =====
// generic single port ram with registered read
`timescale 1ns / 1ps
module kcr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== hw/rtl/kcr_datapath.sv =====
// datapath: request capture, trigger scan registers, entry ram and result
`timescale 1ns / 1ps
module kcr_datapath #(
  parameter int unsigned EntriesPerBank = kcr_pkg::EntriesPerBankDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  kcr_pkg::kcr_cmd_t         cmd_i,
  output kcr_pkg::kcr_sts_t         sts_o,
  input  logic [kcr_pkg::InDataW-1:0] in_data_i,
  output logic [kcr_pkg::OutDataW-1:0] out_data_o
);
  import kcr_pkg::*;

  localparam int unsigned Slots = 2 * EntriesPerBank;
  localparam int unsigned SlotW = $clog2(Slots);
  localparam int unsigned IdxW = (EntriesPerBank > 1) ? $clog2(EntriesPerBank) : 1;
  localparam int unsigned CntBankW = $clog2(EntriesPerBank + 1);

  // captured request
  req_e             req_q;
  logic             bank_q;
  logic [RankW-1:0] rank_q;
  logic [7:0]       key_q;
  entry_t           ent_q;

  // trigger copies and used bits live in flops, read at a scanned slot
  logic      used_q [Slots];
  mod_part_t tm_q   [Slots];
  key_part_t tk_q   [Slots];

  logic [IdxW-1:0]       idx_q;
  logic [RankW-1:0]      rcnt_q;
  logic [CntBankW-1:0]   ucnt_q;
  logic                  found_q;
  logic                  free_found_q;
  logic [IdxW-1:0]       sel_q;

  logic [SlotW-1:0] cur_slot, sel_slot;
  logic             cur_used, trig_eq, key_hit, rank_match, skip_ok;
  entry_t           ram_rd;

  // result registers
  logic                  hit_q;
  logic [UsedCountW-1:0] ucnt_out_q;
  entry_t                rd_q;

  function automatic logic [SlotW-1:0] slot_of(input logic b, input logic [IdxW-1:0] i);
    logic [SlotW:0] s;
    s = (SlotW + 1)'(b) * (SlotW + 1)'(EntriesPerBank) + (SlotW + 1)'(i);
    return s[SlotW-1:0];
  endfunction

  assign cur_slot = slot_of(bank_q, idx_q);
  assign sel_slot = slot_of(bank_q, sel_q);
  assign cur_used = used_q[cur_slot];

  always_comb begin
    logic [2:0] na, nb, ka, kb;
    na = clamp_cnt(tm_q[cur_slot][ModPartW-1 -: CntW], 3'd4);
    nb = ent_q.tm[ModPartW-1 -: CntW];
    ka = clamp_cnt(tk_q[cur_slot][KeyPartW-1 -: CntW], 3'd6);
    kb = ent_q.tk[KeyPartW-1 -: CntW];
    trig_eq = (na == nb) && (ka == kb)
      && mset_eq6({16'd0, tm_q[cur_slot][ModW-1:0]}, {16'd0, ent_q.tm[ModW-1:0]}, na)
      && mset_eq6(tk_q[cur_slot][KeyW-1:0], ent_q.tk[KeyW-1:0], ka);
    key_hit = byte_in({16'd0, tm_q[cur_slot][ModW-1:0]}, na, key_q)
           || byte_in(tk_q[cur_slot][KeyW-1:0], ka, key_q);
  end

  assign rank_match = !rank_q[RankW-1] && (rcnt_q == rank_q);
  assign skip_ok    = !rank_match;

  assign sts_o.req             = req_q;
  assign sts_o.found           = found_q;
  assign sts_o.free_found      = free_found_q;
  assign sts_o.scan_last       = (32'(idx_q) == EntriesPerBank - 1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= req_e'(in_data_i[2:0]);
      bank_q <= in_data_i[3];
      rank_q <= in_data_i[10:4];
      key_q  <= in_data_i[18:11];
      ent_q.tm <= {clamp_cnt(in_data_i[21:19], 3'd4), in_data_i[53:22]};
      ent_q.tk <= {clamp_cnt(in_data_i[56:54], 3'd6), in_data_i[104:57]};
      ent_q.om <= {clamp_cnt(in_data_i[107:105], 3'd4), in_data_i[139:108]};
      ent_q.ok <= {clamp_cnt(in_data_i[142:140], 3'd6), in_data_i[190:143]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      rcnt_q       <= '0;
      ucnt_q       <= '0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      sel_q        <= '0;
      for (int i = 0; i < Slots; i++) used_q[i] <= 1'b0;
    end else begin
      if (cmd_i.scan_start) begin
        idx_q        <= '0;
        rcnt_q       <= '0;
        ucnt_q       <= '0;
        found_q      <= 1'b0;
        free_found_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        if (!sts_o.scan_last) idx_q <= idx_q + IdxW'(1);
        if (cur_used) begin
          rcnt_q <= rcnt_q + RankW'(1);
          ucnt_q <= ucnt_q + CntBankW'(1);
        end
        case (req_q)
          REQ_ADD: begin
            if (cur_used && trig_eq) found_q <= 1'b1;
            if (!cur_used && !free_found_q) begin
              free_found_q <= 1'b1;
              sel_q        <= idx_q;
            end
          end
          REQ_CONFLICT: if (cur_used && skip_ok && trig_eq) found_q <= 1'b1;
          REQ_KEY_USED: if (cur_used && key_hit) found_q <= 1'b1;
          REQ_REMOVE, REQ_READ: begin
            if (cur_used && rank_match && !found_q) begin
              found_q <= 1'b1;
              sel_q   <= idx_q;
            end
          end
          REQ_CLEAR: used_q[cur_slot] <= 1'b0;
          default: ;
        endcase
      end
      if (cmd_i.wr_entry) used_q[sel_slot] <= 1'b1;
      if (cmd_i.wr_zero && req_q == REQ_REMOVE) used_q[sel_slot] <= 1'b0;
    end
  end

  // trigger copies need no reset: they are read only with a used bit set
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_entry) begin
      tm_q[sel_slot] <= ent_q.tm;
      tk_q[sel_slot] <= ent_q.tk;
    end
  end

  logic             ram_we;
  logic [SlotW-1:0] ram_addr;
  assign ram_we   = cmd_i.wr_entry;
  assign ram_addr = sel_slot;

  kcr_ram #(.Width(EntryW), .Depth(Slots)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (cmd_i.rd_issue),
    .addr_i  (ram_addr),
    .wdata_i (ent_q),
    .rdata_o (ram_rd)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_set) begin
      hit_q      <= 1'b0;
      ucnt_out_q <= '0;
      rd_q       <= '0;
      case (req_q)
        REQ_ADD:      hit_q <= !found_q && free_found_q;
        REQ_REMOVE:   hit_q <= found_q;
        REQ_CONFLICT: hit_q <= found_q;
        REQ_KEY_USED: hit_q <= found_q;
        REQ_COUNT:    ucnt_out_q <= UsedCountW'(ucnt_q);
        REQ_READ: begin
          hit_q <= found_q;
          if (found_q) rd_q <= ram_rd;
        end
        default: ;
      endcase
    end
  end

  assign out_data_o = {
    4'd0,
    rd_q.ok[KeyW-1:0], rd_q.ok[KeyPartW-1 -: CntW],
    rd_q.om[ModW-1:0], rd_q.om[ModPartW-1 -: CntW],
    rd_q.tk[KeyW-1:0], rd_q.tk[KeyPartW-1 -: CntW],
    rd_q.tm[ModW-1:0], rd_q.tm[ModPartW-1 -: CntW],
    ucnt_out_q, hit_q
  };
endmodule

// ===== hw/rtl/kcr_ctrl.sv =====
// controller state machine and stream handshake
`timescale 1ns / 1ps
module kcr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  kcr_pkg::kcr_sts_t sts_i,
  output kcr_pkg::kcr_cmd_t cmd_o
);
  import kcr_pkg::*;

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d    = state_q;
    ovalid_d   = ovalid_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load       = 1'b1;
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          if (sts_i.req == REQ_ADD) state_d = ST_WRITE;
          else if (sts_i.req == REQ_READ) state_d = ST_READ;
          else state_d = ST_DONE;
        end
      end
      ST_WRITE: begin
        cmd_o.wr_entry = sts_i.free_found && !sts_i.found;
        state_d        = ST_DONE;
      end
      ST_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_READ_WAIT;
      end
      ST_READ_WAIT: begin
        // ram read data arrives
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // wait until the previous result is gone
        if (!ovalid_q || out_ready_i) begin
          cmd_o.res_set = 1'b1;
          cmd_o.wr_zero = sts_i.found;
          ovalid_d      = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

// ===== hw/rtl/key_combo_remap_table.sv =====
// top level of the key combo remap table
// usage:
//   one request item enters on s_axis (req_type, bank, rank, phys_key and two
//   combos in tdata); one result item leaves on m_axis (hit, used_count and
//   the combos of the entry read).
// scan and throughput:
//   an item scans the selected bank one slot per cycle; an add then writes
//   its entry, and a read issues the ram read and waits for its data, before
//   the result is set; one item is in work at a time and the next is
//   accepted once its result is loaded into the output register.
// reset:
//   all used marks clear at once; the entry ram holds no reset and is only
//   read behind a used mark, so the block is ready right after reset.
// stall:
//   a result waits in the output register while m_axis_tready is low; the
//   next item is accepted and scanned, and its result waits for the slot.
`timescale 1ns / 1ps
module key_combo_remap_table #(
  parameter int unsigned ENTRIES_PER_BANK = kcr_pkg::EntriesPerBankDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // req_type, bank, rank, phys_key, trig_mod_count, trig_mods, trig_key_count,
  // trig_keys, out_mod_count, out_mods, out_key_count, out_keys, zero fill
  input  logic [kcr_pkg::InDataW-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // hit, used_count, rd_trig_mod_count, rd_trig_mods, rd_trig_key_count,
  // rd_trig_keys, rd_out_mod_count, rd_out_mods, rd_out_key_count,
  // rd_out_keys, zero fill
  output logic [kcr_pkg::OutDataW-1:0] m_axis_tdata
);
  import kcr_pkg::*;

  kcr_cmd_t cmd;
  kcr_sts_t sts;

  kcr_datapath #(.EntriesPerBank(ENTRIES_PER_BANK)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (s_axis_tdata),
    .out_data_o (m_axis_tdata)
  );

  kcr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );
endmodule

// ===== hw/rtl/kcr_checker.sv =====
// port level checker for the key combo remap table, bound to the top level
`timescale 1ns / 1ps
module kcr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [kcr_pkg::OutDataW-1:0] m_axis_tdata
);
  import kcr_pkg::*;

  // one item at a time: no accept in the cycle right after an accept
  a_no_back_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("accept right after accept");

  // result never appears the cycle after accept
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !$rose(m_axis_tvalid))
    else $error("result too early");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  // count and hit are never both set
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && (m_axis_tdata[7:1] != 7'd0)))
    else $error("hit with used count");
endmodule

bind key_combo_remap_table kcr_checker u_kcr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== dv/tb.sv =====
// testbench for the key combo remap table: random and directed requests against a scoreboard
`timescale 1ns / 1ps
module tb;
  import kcr_pkg::*;

  localparam int unsigned Slots = 2 * EntriesPerBankDefault;
  localparam int unsigned WatchLimit = 5000;

  // request item, first field in the lowest bits
  typedef struct packed {
    logic [InDataW-192:0] fill;
    logic [47:0] out_keys;
    logic [2:0]  out_key_count;
    logic [31:0] out_mods;
    logic [2:0]  out_mod_count;
    logic [47:0] trig_keys;
    logic [2:0]  trig_key_count;
    logic [31:0] trig_mods;
    logic [2:0]  trig_mod_count;
    logic [7:0]  phys_key;
    logic signed [6:0] rank;
    logic        bank;
    req_e        req_type;
  } request_t;

  typedef struct packed {
    logic [OutDataW-181:0] fill;
    logic [47:0] rd_out_keys;
    logic [2:0]  rd_out_key_count;
    logic [31:0] rd_out_mods;
    logic [2:0]  rd_out_mod_count;
    logic [47:0] rd_trig_keys;
    logic [2:0]  rd_trig_key_count;
    logic [31:0] rd_trig_mods;
    logic [2:0]  rd_trig_mod_count;
    logic [6:0]  used_count;
    logic        hit;
  } answer_t;

  class remap_scoreboard;
    bit         used[Slots];
    logic [63:0] tm_s[Slots];
    logic [63:0] tk_s[Slots];
    logic [63:0] om_s[Slots];
    logic [63:0] ok_s[Slots];
    answer_t    pending[$];
    int         errors;

    function void wipe(int s);
      used[s] = 0;
      tm_s[s] = '0;
      tk_s[s] = '0;
      om_s[s] = '0;
      ok_s[s] = '0;
    endfunction

    function int part_cnt(logic [63:0] w, int cpos, int maxn);
      int n;
      n = int'((w >> cpos) & 64'd7);
      return (n > maxn) ? maxn : n;
    endfunction

    function bit part_same(logic [63:0] a, logic [63:0] b, int cpos, int maxn);
      logic [7:0] sa[6];
      logic [7:0] sb[6];
      logic [7:0] t;
      int n;
      n = part_cnt(a, cpos, maxn);
      if (n != part_cnt(b, cpos, maxn)) return 0;
      for (int i = 0; i < n; i++) begin
        sa[i] = a[8*i +: 8];
        sb[i] = b[8*i +: 8];
      end
      for (int i = 0; i < n; i++)
        for (int j = 0; j + 1 < n - i; j++) begin
          if (sa[j] > sa[j+1]) begin t = sa[j]; sa[j] = sa[j+1]; sa[j+1] = t; end
          if (sb[j] > sb[j+1]) begin t = sb[j]; sb[j] = sb[j+1]; sb[j+1] = t; end
        end
      for (int i = 0; i < n; i++) if (sa[i] != sb[i]) return 0;
      return 1;
    endfunction

    function bit trigger_taken(int base, logic [63:0] tm, logic [63:0] tk, int skip);
      int idx;
      idx = 0;
      for (int i = 0; i < EntriesPerBankDefault; i++) begin
        if (!used[base+i]) continue;
        if (idx != skip && part_same(tm_s[base+i], tm, 32, 4) &&
            part_same(tk_s[base+i], tk, 48, 6)) return 1;
        idx++;
      end
      return 0;
    endfunction

    function int slot_at(int base, int rank);
      int n;
      n = 0;
      if (rank < 0) return -1;
      for (int i = 0; i < EntriesPerBankDefault; i++) begin
        if (!used[base+i]) continue;
        if (n == rank) return base + i;
        n++;
      end
      return -1;
    endfunction

    function bit key_in(logic [63:0] w, int cpos, int maxn, logic [7:0] k);
      for (int i = 0; i < part_cnt(w, cpos, maxn); i++) if (w[8*i +: 8] == k) return 1;
      return 0;
    endfunction

    function void note_request(request_t r);
      answer_t e;
      int base;
      int rk;
      int s;
      logic [63:0] tm, tk, om, ok;
      e = '0;
      base = r.bank * EntriesPerBankDefault;
      rk = int'(r.rank);
      tm = {29'd0, (r.trig_mod_count > 4) ? 3'd4 : r.trig_mod_count, r.trig_mods};
      tk = {13'd0, (r.trig_key_count > 6) ? 3'd6 : r.trig_key_count, r.trig_keys};
      om = {29'd0, (r.out_mod_count > 4) ? 3'd4 : r.out_mod_count, r.out_mods};
      ok = {13'd0, (r.out_key_count > 6) ? 3'd6 : r.out_key_count, r.out_keys};
      case (r.req_type)
        REQ_CLEAR: for (int i = 0; i < EntriesPerBankDefault; i++) wipe(base + i);
        REQ_ADD: if (!trigger_taken(base, tm, tk, -1)) begin
          for (int i = 0; i < EntriesPerBankDefault; i++) begin
            if (!used[base+i]) begin
              used[base+i] = 1;
              tm_s[base+i] = tm;
              tk_s[base+i] = tk;
              om_s[base+i] = om;
              ok_s[base+i] = ok;
              e.hit = 1;
              break;
            end
          end
        end
        REQ_REMOVE: begin
          s = slot_at(base, rk);
          if (s >= 0) begin wipe(s); e.hit = 1; end
        end
        REQ_COUNT: for (int i = 0; i < EntriesPerBankDefault; i++) e.used_count += used[base+i];
        REQ_READ: begin
          s = slot_at(base, rk);
          if (s >= 0) begin
            e.hit = 1;
            e.rd_trig_mod_count = tm_s[s][34:32];
            e.rd_trig_mods      = tm_s[s][31:0];
            e.rd_trig_key_count = tk_s[s][50:48];
            e.rd_trig_keys      = tk_s[s][47:0];
            e.rd_out_mod_count  = om_s[s][34:32];
            e.rd_out_mods       = om_s[s][31:0];
            e.rd_out_key_count  = ok_s[s][50:48];
            e.rd_out_keys       = ok_s[s][47:0];
          end
        end
        REQ_CONFLICT: e.hit = trigger_taken(base, tm, tk, rk);
        REQ_KEY_USED:
          for (int i = 0; i < EntriesPerBankDefault; i++)
            if (used[base+i] && (key_in(tm_s[base+i], 32, 4, r.phys_key) ||
                                 key_in(tk_s[base+i], 48, 6, r.phys_key))) e.hit = 1;
        default: ;
      endcase
      pending.push_back(e);
    endfunction

    function void check_result(answer_t a);
      answer_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item %p", a);
        return;
      end
      e = pending.pop_front();
      a.fill = '0;
      if (a.hit !== e.hit || a.used_count !== e.used_count ||
          a.rd_trig_mod_count !== e.rd_trig_mod_count || a.rd_trig_mods !== e.rd_trig_mods ||
          a.rd_trig_key_count !== e.rd_trig_key_count || a.rd_trig_keys !== e.rd_trig_keys ||
          a.rd_out_mod_count !== e.rd_out_mod_count || a.rd_out_mods !== e.rd_out_mods ||
          a.rd_out_key_count !== e.rd_out_key_count || a.rd_out_keys !== e.rd_out_keys) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", e, a);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  remap_scoreboard sb = new();
  bit quiet;
  int stall_left = 0;
  int idle_cycles = 0;
  logic [7:0] alphabet[6] = '{8'h04, 8'h05, 8'h06, 8'he0, 8'he1, 8'h2c};
  request_t recent[$];

  key_combo_remap_table uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_request(request_t'(s_axis_tdata));
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(answer_t'(m_axis_tdata));
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver stalls in bursts
  always @(negedge clk_i) begin
    if (!quiet && stall_left == 0 && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 11);
    m_axis_tready <= (stall_left == 0);
    if (stall_left > 0) stall_left--;
  end

  task automatic put_item(request_t r);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    r.fill = '0;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= r;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic request_t noise_item();
    logic [255:0] w;
    w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return w[InDataW-1:0];
  endfunction

  // well-formed combo bytes drawn from a few codes so that triggers collide
  function automatic request_t combo_item(req_e op, bit bank);
    request_t r;
    r = noise_item();
    r.req_type = op;
    r.bank = bank;
    r.trig_mod_count = 3'($urandom_range(0, 4));
    r.trig_key_count = 3'($urandom_range(0, 6));
    r.out_mod_count = 3'($urandom_range(0, 4));
    r.out_key_count = 3'($urandom_range(0, 6));
    for (int i = 0; i < 4; i++) r.trig_mods[8*i +: 8] = alphabet[$urandom_range(0, 5)];
    for (int i = 0; i < 6; i++) r.trig_keys[8*i +: 8] = alphabet[$urandom_range(0, 5)];
    if ($urandom_range(0, 3) != 0) begin
      r.trig_mod_count = 3'($urandom_range(0, 1));
      r.trig_key_count = 3'($urandom_range(0, 2));
    end
    r.rank = ($urandom_range(0, 9) == 0) ? 7'(64 + $urandom_range(0, 63))
                                         : 7'($urandom_range(0, 17));
    r.phys_key = ($urandom_range(0, 3) == 0) ? 8'($urandom) : alphabet[$urandom_range(0, 5)];
    return r;
  endfunction

  function automatic request_t plain(req_e op, bit bank, int rank);
    request_t r;
    r = '0;
    r.req_type = op;
    r.bank = bank;
    r.rank = 7'(rank);
    return r;
  endfunction

  initial begin
    request_t a, b;
    int pick;
    quiet = 0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    put_item(plain(REQ_CLEAR, 0, 0));
    put_item(plain(REQ_CLEAR, 1, 0));
    put_item(plain(REQ_COUNT, 0, 0));
    put_item(plain(REQ_READ, 0, 0));
    a = plain(REQ_ADD, 0, 0);
    a.trig_mod_count = 3'd2; a.trig_mods = 32'hff00_e1e0;
    a.trig_key_count = 3'd3; a.trig_keys = 48'h1111_2206_0504;
    a.out_mod_count = 3'd4; a.out_mods = 32'hffff_ffff;
    a.out_key_count = 3'd6; a.out_keys = 48'hffff_ffff_ffff;
    put_item(a);
    b = a;
    b.trig_mods = 32'h0000_e0e1; b.trig_keys = 48'h0000_0004_0605;
    put_item(b);
    b = a;
    b.trig_mod_count = 3'd7; b.trig_key_count = 3'd7;
    b.out_mod_count = 3'd7; b.out_key_count = 3'd7;
    put_item(b);
    a.bank = 1;
    put_item(a);
    put_item(plain(REQ_COUNT, 0, 0));
    put_item(plain(REQ_READ, 0, 1));
    put_item(plain(REQ_READ, 0, -1));
    put_item(plain(REQ_READ, 0, 63));
    a.bank = 0; a.req_type = REQ_CONFLICT;
    a.rank = -7'sd1; put_item(a);
    a.rank = 7'sd0;  put_item(a);
    a.rank = -7'sd5; put_item(a);
    b = plain(REQ_KEY_USED, 0, 0);
    b.phys_key = 8'h05; put_item(b);
    b.phys_key = 8'h22; put_item(b);
    put_item(plain(REQ_NONE, 0, 0));
    put_item(plain(REQ_REMOVE, 0, 5));
    put_item(plain(REQ_REMOVE, 0, 0));
    put_item(plain(REQ_READ, 0, 0));
    // fill the bank, then one add too many
    for (int i = 0; i < EntriesPerBankDefault; i++) begin
      b = plain(REQ_ADD, 0, 0);
      b.trig_key_count = 3'd1; b.trig_keys = 48'h30 + 48'(i);
      put_item(b);
    end
    put_item(plain(REQ_COUNT, 0, 0));
    put_item(plain(REQ_CLEAR, 0, 0));

    for (int n = 0; n < 700; n++) begin
      if (n == 600) quiet = 1;
      if (n == 300) begin
        // hold the sender until the block has drained
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk_i);
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) a = noise_item();
      else if (pick < 38) a = combo_item(REQ_ADD, $urandom_range(0, 1));
      else if (pick < 48) a = combo_item(REQ_REMOVE, $urandom_range(0, 1));
      else if (pick < 56) a = combo_item(REQ_COUNT, $urandom_range(0, 1));
      else if (pick < 74) a = combo_item(REQ_READ, $urandom_range(0, 1));
      else if (pick < 88) a = combo_item(REQ_CONFLICT, $urandom_range(0, 1));
      else if (pick < 97) a = combo_item(REQ_KEY_USED, $urandom_range(0, 1));
      else a = combo_item(REQ_CLEAR, $urandom_range(0, 1));
      // reuse a recent trigger, bytes reordered, for collisions
      if ((a.req_type == REQ_CONFLICT || a.req_type == REQ_ADD) && recent.size() > 0 &&
          $urandom_range(0, 1) == 0) begin
        b = recent[$urandom_range(0, recent.size() - 1)];
        a.bank = b.bank;
        a.trig_mod_count = b.trig_mod_count;
        a.trig_key_count = b.trig_key_count;
        a.trig_mods = {b.trig_mods[7:0], b.trig_mods[31:8]};
        a.trig_keys = b.trig_keys;
        if (b.trig_key_count == 2) a.trig_keys[15:0] = {b.trig_keys[7:0], b.trig_keys[15:8]};
        if (a.trig_mod_count > 1) a.trig_mods = b.trig_mods;
      end
      if (a.req_type == REQ_ADD) begin
        recent.push_back(a);
        if (recent.size() > 8) void'(recent.pop_front());
      end
      put_item(a);
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== key_combo_remap_table.f =====
hw/rtl/kcr_pkg.sv
hw/rtl/kcr_ram.sv
hw/rtl/kcr_datapath.sv
hw/rtl/kcr_ctrl.sv
hw/rtl/key_combo_remap_table.sv
hw/rtl/kcr_checker.sv
dv/tb.sv
